// File: rtl/rqarb_pkg.sv
// ----------------------------------------------------------------------------
// Retry arbiter package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rqarb_pkg;

  // Sources per class and counter width.
  localparam int SOURCE_COUNT = 16;
  localparam int COUNT_WIDTH  = 8;

  localparam int SRC_W     = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;
  localparam int SRC_IN_W  = 4;
  localparam int CLASS_COUNT = 6;
  localparam int CLASS_W   = 3;
  localparam int ADDR_W    = CLASS_W + SRC_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Stream widths: payload bits rounded up to whole bytes.
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;

  // Command classes.
  localparam logic [CLASS_W-1:0] CL_HPR   = 3'd0;
  localparam logic [CLASS_W-1:0] CL_LPR   = 3'd1;
  localparam logic [CLASS_W-1:0] CL_GPR   = 3'd2;
  localparam logic [CLASS_W-1:0] CL_TPW   = 3'd3;
  localparam logic [CLASS_W-1:0] CL_GPW   = 3'd4;
  localparam logic [CLASS_W-1:0] CL_CMO   = 3'd5;
  localparam logic [CLASS_W-1:0] NO_CLASS = 3'd7;

  // Request functions.
  localparam logic [1:0] FN_RECORD  = 2'd0;
  localparam logic [1:0] FN_RELEASE = 2'd1;
  localparam logic [1:0] FN_GRANT   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_SATURATED = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_GPR_AGE = 1'b0;
  localparam logic CFG_GPW_AGE = 1'b1;

  typedef struct packed {
    logic capture;  // latch the incoming request and issue the counter read
    logic commit;   // write the counter back and load the result register
  } cmd_t;

  typedef struct packed {
    logic out_free; // result register is empty or being taken this cycle
  } sts_t;

endpackage

// File: rtl/retry_queue_two_level_arbiter.sv
// ----------------------------------------------------------------------------
// Retry queue two-level arbiter
// Per-class, per-source pending-retry counters with class and source arbitration.
// ----------------------------------------------------------------------------
// Each request is handled in a capture step and a commit step: the capture
// step accepts it, runs the class and source arbitration from the per-entry
// nonzero flags and issues the read of the counter RAM; the commit step writes
// the updated counter back and loads the result register. The counter RAM's
// registered read sets this split. The next request is accepted while a result
// still waits in the result register; the commit step waits for as long as the
// result register stays full. Reset needs no clearing pass: a counter whose
// nonzero flag is clear reads as zero, so all counters are empty right after
// reset. The age-enable registers are written through the cfg channel, which is
// always ready, and should be written only while no request is in flight.
// ----------------------------------------------------------------------------
module retry_queue_two_level_arbiter (
  input  logic                              clk,
  input  logic                              rst,
  // Request stream.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // tdata from bit 0: req_class[2:0], source[6:3], gpr_aged[7], gpw_aged[8], zero pad.
  input  logic [rqarb_pkg::IN_DATA_W-1:0]   s_tdata,
  // tuser from bit 0: func[1:0].
  input  logic [rqarb_pkg::IN_USER_W-1:0]   s_tuser,
  // Result stream.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // tdata from bit 0: grant_valid[0], grant_class[3:1], grant_source[7:4],
  // pending_mask[13:8], all_empty[14], status[16:15], zero pad.
  output logic [rqarb_pkg::OUT_DATA_W-1:0]  m_tdata,
  // Configuration writes: index 0 gpr_age_enable, index 1 gpw_age_enable.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic                              cfg_data
);

  rqarb_pkg::cmd_t cmd;
  rqarb_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  rqarb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  rqarb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// File: rtl/rqarb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rqarb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/rqarb_ctrl.sv
// ----------------------------------------------------------------------------
// Retry arbiter controller
// Two-state sequencer: take a request, then commit it once the result
// register can accept the outcome.
// ----------------------------------------------------------------------------
module rqarb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output rqarb_pkg::cmd_t cmd,
  input  rqarb_pkg::sts_t sts
);

  typedef enum logic {
    S_IDLE,
    S_COMMIT
  } state_t;

  state_t state;
  logic   ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ready <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid && ready) begin
            state <= S_COMMIT;
            ready <= 1'b0;
          end
        end
        S_COMMIT: begin
          if (sts.out_free) begin
            state <= S_IDLE;
            ready <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
          ready <= 1'b1;
        end
      endcase
    end
  end

  assign s_tready    = ready;
  assign cmd.capture = s_tvalid && ready;
  assign cmd.commit  = (state == S_COMMIT) && sts.out_free;

endmodule

// File: rtl/rqarb_dp.sv
// ----------------------------------------------------------------------------
// Retry arbiter datapath
// Counter store, nonzero flags, class and source arbitration, result register.
// ----------------------------------------------------------------------------
module rqarb_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  rqarb_pkg::cmd_t                     cmd,
  output rqarb_pkg::sts_t                     sts,
  input  logic [rqarb_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [rqarb_pkg::IN_USER_W-1:0]     s_tuser,
  input  logic                                cfg_valid,
  input  logic                                cfg_index,
  input  logic                                cfg_data,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [rqarb_pkg::OUT_DATA_W-1:0]    m_tdata
);

  localparam int SC  = rqarb_pkg::SOURCE_COUNT;
  localparam int CC  = rqarb_pkg::CLASS_COUNT;
  localparam int SW  = rqarb_pkg::SRC_W;
  localparam int CW  = rqarb_pkg::CLASS_W;
  localparam int NW  = rqarb_pkg::COUNT_WIDTH;

  // Configuration and arbitration state.
  logic                      gpr_age_en;
  logic                      gpw_age_en;
  logic                      rd_ptr;
  logic                      wr_ptr;
  logic [1:0]                grp_ptr;
  logic [CC-1:0][SW-1:0]     src_ptr;
  logic [CC-1:0][SC-1:0]     nz;

  // Captured request.
  logic [1:0]    op_func;
  logic [CW-1:0] op_cls;
  logic [SW-1:0] op_src;
  logic          op_ok;
  logic          op_found;

  // Result register fields.
  logic          r_gvalid;
  logic [CW-1:0] r_gclass;
  logic [3:0]    r_gsrc;
  logic [CC-1:0] r_pmask;
  logic          r_empty;
  logic [1:0]    r_status;

  // Request decode.
  logic [1:0]                  in_func;
  logic [CW-1:0]               in_cls;
  logic [rqarb_pkg::SRC_IN_W-1:0] in_src;
  logic                        in_gpr_aged;
  logic                        in_gpw_aged;
  logic                        idx_ok;
  logic [SW-1:0]               src_idx;

  assign in_func     = s_tuser;
  assign in_cls      = s_tdata[2:0];
  assign in_src      = s_tdata[6:3];
  assign in_gpr_aged = s_tdata[7];
  assign in_gpw_aged = s_tdata[8];
  assign idx_ok      = (in_cls < CW'(CC)) && (int'(in_src) < SC);
  assign src_idx     = SW'(in_src);

  // Class arbitration.
  logic [CC-1:0]       pending;
  logic [CW-1:0]       rw;
  logic [CW-1:0]       ww;
  logic [3:0][CW-1:0]  cand;
  logic [CW-1:0]       win;
  logic                win_ok;
  logic [1:0]          grp_next;
  logic                rd_next;
  logic                wr_next;
  logic [1:0]          k;

  always_comb begin
    for (int c = 0; c < CC; c++) begin
      pending[c] = |nz[c];
    end
  end

  always_comb begin
    win      = rqarb_pkg::NO_CLASS;
    grp_next = grp_ptr;
    rd_next  = rd_ptr;
    wr_next  = wr_ptr;
    k        = '0;
    rw       = rqarb_pkg::NO_CLASS;
    ww       = rqarb_pkg::NO_CLASS;
    cand     = '0;
    if (gpr_age_en && in_gpr_aged && pending[rqarb_pkg::CL_GPR]) begin
      win = rqarb_pkg::CL_GPR;
    end else if (gpw_age_en && in_gpw_aged && pending[rqarb_pkg::CL_GPW]) begin
      win = rqarb_pkg::CL_GPW;
    end else begin
      // Each pair picks by its alternation bit when both members are pending.
      if (pending[rqarb_pkg::CL_LPR] && pending[rqarb_pkg::CL_GPR]) begin
        rw = rd_ptr ? rqarb_pkg::CL_LPR : rqarb_pkg::CL_GPR;
      end else if (pending[rqarb_pkg::CL_LPR]) begin
        rw = rqarb_pkg::CL_LPR;
      end else if (pending[rqarb_pkg::CL_GPR]) begin
        rw = rqarb_pkg::CL_GPR;
      end
      if (pending[rqarb_pkg::CL_TPW] && pending[rqarb_pkg::CL_GPW]) begin
        ww = wr_ptr ? rqarb_pkg::CL_TPW : rqarb_pkg::CL_GPW;
      end else if (pending[rqarb_pkg::CL_TPW]) begin
        ww = rqarb_pkg::CL_TPW;
      end else if (pending[rqarb_pkg::CL_GPW]) begin
        ww = rqarb_pkg::CL_GPW;
      end
      cand[0] = rw;
      cand[1] = ww;
      cand[2] = pending[rqarb_pkg::CL_HPR] ? rqarb_pkg::CL_HPR : rqarb_pkg::NO_CLASS;
      cand[3] = pending[rqarb_pkg::CL_CMO] ? rqarb_pkg::CL_CMO : rqarb_pkg::NO_CLASS;
      // Walk from the farthest slot down so the nearest one after the pointer wins.
      for (int i = 3; i >= 0; i--) begin
        k = grp_ptr + 2'(i) + 2'd1;
        if (cand[k] != rqarb_pkg::NO_CLASS) begin
          win      = cand[k];
          grp_next = k;
        end
      end
      // A pair that lost while both members waited keeps its preference.
      if (rw != rqarb_pkg::NO_CLASS &&
          !(win != rw && pending[rqarb_pkg::CL_LPR] && pending[rqarb_pkg::CL_GPR])) begin
        rd_next = (rw == rqarb_pkg::CL_LPR) ? 1'b0 : 1'b1;
      end
      if (ww != rqarb_pkg::NO_CLASS &&
          !(win != ww && pending[rqarb_pkg::CL_TPW] && pending[rqarb_pkg::CL_GPW])) begin
        wr_next = (ww == rqarb_pkg::CL_TPW) ? 1'b0 : 1'b1;
      end
    end
  end

  assign win_ok = (win != rqarb_pkg::NO_CLASS);

  // Source round robin inside the winning class.
  logic [SC-1:0] win_nz;
  logic [SW-1:0] win_ptr;
  logic [SW:0]   ssum;
  logic [SW-1:0] gsrc;

  always_comb begin
    win_nz  = '0;
    win_ptr = '0;
    for (int c = 0; c < CC; c++) begin
      if (win == CW'(c)) begin
        win_nz  = nz[c];
        win_ptr = src_ptr[c];
      end
    end
  end

  always_comb begin
    gsrc = '0;
    ssum = '0;
    for (int i = SC - 1; i >= 0; i--) begin
      ssum = {1'b0, win_ptr} + (SW+1)'(i) + (SW+1)'(1);
      if (ssum >= (SW+1)'(SC)) begin
        ssum = ssum - (SW+1)'(SC);
      end
      if (win_nz[ssum[SW-1:0]]) begin
        gsrc = ssum[SW-1:0];
      end
    end
  end

  // Counter store.
  logic                          is_grant;
  logic [CW-1:0]                 rd_cls;
  logic [SW-1:0]                 rd_src;
  logic [NW-1:0]                 ram_q;
  logic                          we;
  logic [NW-1:0]                 wdata;

  assign is_grant = (in_func == rqarb_pkg::FN_GRANT);
  assign rd_cls   = is_grant ? win : in_cls;
  assign rd_src   = is_grant ? gsrc : src_idx;

  rqarb_ram #(
    .WIDTH (NW),
    .DEPTH (rqarb_pkg::RAM_DEPTH)
  ) u_counts (
    .clk   (clk),
    .we    (we && cmd.commit),
    .waddr ({op_cls, op_src}),
    .wdata (wdata),
    .re    (cmd.capture),
    .raddr ({rd_cls, rd_src}),
    .rdata (ram_q)
  );

  // Commit: a counter whose nonzero flag is clear reads as zero.
  logic          cur_nz;
  logic [NW-1:0] cnt;
  logic [1:0]    status;
  logic          gvalid;
  logic [CC-1:0][SC-1:0] nz_next;
  logic [CC-1:0] pmask_next;

  always_comb begin
    cur_nz = 1'b0;
    for (int c = 0; c < CC; c++) begin
      if (op_cls == CW'(c)) begin
        cur_nz = nz[c][op_src];
      end
    end
  end

  assign cnt = cur_nz ? ram_q : '0;

  always_comb begin
    we     = 1'b0;
    wdata  = cnt;
    status = rqarb_pkg::ST_OK;
    gvalid = 1'b0;
    case (op_func)
      rqarb_pkg::FN_RECORD: begin
        if (!op_ok) begin
          status = rqarb_pkg::ST_BAD_INDEX;
        end else if (cnt == rqarb_pkg::COUNT_MAX) begin
          status = rqarb_pkg::ST_SATURATED;
        end else begin
          we    = 1'b1;
          wdata = cnt + NW'(1);
        end
      end
      rqarb_pkg::FN_RELEASE: begin
        if (!op_ok) begin
          status = rqarb_pkg::ST_BAD_INDEX;
        end else if (cnt == '0) begin
          status = rqarb_pkg::ST_UNDERFLOW;
        end else begin
          we    = 1'b1;
          wdata = cnt - NW'(1);
        end
      end
      rqarb_pkg::FN_GRANT: begin
        if (op_found) begin
          we     = 1'b1;
          wdata  = cnt - NW'(1);
          gvalid = 1'b1;
        end
      end
      default: begin
        status = rqarb_pkg::ST_BAD_INDEX;
      end
    endcase
  end

  always_comb begin
    nz_next = nz;
    for (int c = 0; c < CC; c++) begin
      if (we && op_cls == CW'(c)) begin
        nz_next[c][op_src] = (wdata != '0);
      end
    end
    for (int c = 0; c < CC; c++) begin
      pmask_next[c] = |nz_next[c];
    end
  end

  assign sts.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gpr_age_en <= 1'b0;
      gpw_age_en <= 1'b0;
      rd_ptr     <= 1'b0;
      wr_ptr     <= 1'b0;
      grp_ptr    <= 2'd3;
      src_ptr    <= {CC{SW'(SC - 1)}};
      nz         <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == rqarb_pkg::CFG_GPR_AGE) begin
          gpr_age_en <= cfg_data;
        end else begin
          gpw_age_en <= cfg_data;
        end
      end
      // Pointers are only read at capture, so they move right away.
      if (cmd.capture && is_grant) begin
        grp_ptr <= grp_next;
        rd_ptr  <= rd_next;
        wr_ptr  <= wr_next;
        for (int c = 0; c < CC; c++) begin
          if (win == CW'(c)) begin
            src_ptr[c] <= gsrc;
          end
        end
      end
      if (cmd.commit) begin
        nz       <= nz_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_func  <= in_func;
      op_cls   <= rd_cls;
      op_src   <= rd_src;
      op_ok    <= idx_ok;
      op_found <= win_ok;
    end
    if (cmd.commit) begin
      r_gvalid <= gvalid;
      r_gclass <= gvalid ? op_cls : '0;
      r_gsrc   <= gvalid ? 4'(op_src) : 4'd0;
      r_pmask  <= pmask_next;
      r_empty  <= (pmask_next == '0);
      r_status <= status;
    end
  end

  assign m_tdata = {7'd0, r_status, r_empty, r_pmask, r_gsrc, r_gclass, r_gvalid};

  a_grant_class: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && r_gvalid) |-> (r_gclass <= rqarb_pkg::CL_CMO))
    else $error("granted class out of range");

  a_empty_mask: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (r_empty == (r_pmask == '0)))
    else $error("all_empty disagrees with pending mask");

  a_grant_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && r_gvalid) |-> (r_status == rqarb_pkg::ST_OK && r_pmask != '0 ||
                                r_status == rqarb_pkg::ST_OK && r_empty))
    else $error("grant reported with a non-ok status");

endmodule

// File: dv/tb_retry_queue_two_level_arbiter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Retry queue two-level arbiter testbench
// Drives record, release and grant requests through the request stream with
// bursty timing. The result stream is stalled on a changing pattern. An
// in-bench model of the counters and of both arbitration levels predicts
// every result, which is checked field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb_retry_queue_two_level_arbiter;
  import rqarb_pkg::*;

  // Per-request allowance inside the block; end-of-phase waits use it.
  localparam int GRANT_CYCLES = 2;
  // Codes the block must reject: the spare class and the unused function.
  localparam logic [CLASS_W-1:0] CL_SPARE  = 3'd6;
  localparam logic [1:0]         FN_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         func;
    logic [CLASS_W-1:0] req_class;
    logic [3:0]         source;
    logic               gpr_aged;
    logic               gpw_aged;
    bit                 drain_first; // hold this request until all results are back
  } retry_req_t;

  // Declared from the top bit down so that grant_valid lands in bit 0.
  typedef struct packed {
    logic [1:0]             status;
    logic                   all_empty;
    logic [CLASS_COUNT-1:0] pending_mask;
    logic [3:0]             grant_source;
    logic [CLASS_W-1:0]     grant_class;
    logic                   grant_valid;
  } retry_result_t;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #2 clk = ~clk;

  // Block ports. Every input starts at a known value.
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [IN_USER_W-1:0]  s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = 1'b0;
  logic                  cfg_data  = 1'b0;

  retry_queue_two_level_arbiter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Model state: one counter per class and source, the two pair pointers, the
  // group round-robin pointer, one source pointer per class and the age enables.
  logic [COUNT_WIDTH-1:0] retry_cnt [CLASS_COUNT][SOURCE_COUNT];
  logic                   rd_pair_ptr;
  logic                   wr_pair_ptr;
  logic [1:0]             grp_ptr;
  logic [SRC_W-1:0]       src_ptr [CLASS_COUNT];
  logic                   gpr_age_en;
  logic                   gpw_age_en;

  retry_req_t    queued_requests[$];
  retry_result_t predicted_results[$];
  int            mismatch_count = 0;

  // A class is busy when any of its source counters is nonzero.
  function automatic logic [CLASS_COUNT-1:0] busy_classes();
    logic [CLASS_COUNT-1:0] m;
    m = '0;
    for (int c = 0; c < CLASS_COUNT; c++)
      for (int s = 0; s < SOURCE_COUNT; s++)
        if (retry_cnt[c][s] != '0) m[c] = 1'b1;
    return m;
  endfunction

  // Winner of one pair; with both members busy the pointer decides.
  function automatic logic [CLASS_W-1:0] pair_winner(logic a_busy, logic b_busy,
                                                     logic prefer_a,
                                                     logic [CLASS_W-1:0] a,
                                                     logic [CLASS_W-1:0] b);
    if (a_busy && b_busy) return prefer_a ? a : b;
    if (a_busy) return a;
    if (b_busy) return b;
    return NO_CLASS;
  endfunction

  // The pair pointer stays locked when neither member was busy, or when both
  // were busy but the pair lost the group round robin. Otherwise it turns to the other member.
  function automatic logic pair_ptr_next(logic ptr, logic [CLASS_W-1:0] pair_win,
                                         logic [CLASS_W-1:0] won, logic both_busy,
                                         logic [CLASS_W-1:0] a);
    if (pair_win == NO_CLASS) return ptr;
    if (won != pair_win && both_busy) return ptr;
    return (pair_win == a) ? 1'b0 : 1'b1;
  endfunction

  // Applies one request to the model and returns the result it produces.
  function automatic retry_result_t apply_retry_request(retry_req_t rq);
    retry_result_t          res;
    logic [CLASS_COUNT-1:0] busy;
    logic [CLASS_W-1:0]     won;
    logic [CLASS_W-1:0]     rd_win;
    logic [CLASS_W-1:0]     wr_win;
    logic [CLASS_W-1:0]     cand [4];
    logic [1:0]             k;
    logic                   index_ok;
    int                     s;
    res = '0;
    won = NO_CLASS;
    index_ok = (rq.req_class < CLASS_COUNT) && (int'(rq.source) < SOURCE_COUNT);
    case (rq.func)
      FN_RECORD: begin
        if (!index_ok) res.status = ST_BAD_INDEX;
        else if (retry_cnt[rq.req_class][rq.source] == COUNT_MAX) res.status = ST_SATURATED;
        else retry_cnt[rq.req_class][rq.source] += 1'b1;
      end
      FN_RELEASE: begin
        if (!index_ok) res.status = ST_BAD_INDEX;
        else if (retry_cnt[rq.req_class][rq.source] == '0) res.status = ST_UNDERFLOW;
        else retry_cnt[rq.req_class][rq.source] -= 1'b1;
      end
      FN_GRANT: begin
        busy = busy_classes();
        // An aged class jumps the queue and leaves the pair and group pointers alone.
        if (gpr_age_en && rq.gpr_aged && busy[CL_GPR]) begin
          won = CL_GPR;
        end else if (gpw_age_en && rq.gpw_aged && busy[CL_GPW]) begin
          won = CL_GPW;
        end else begin
          rd_win = pair_winner(busy[CL_LPR], busy[CL_GPR], rd_pair_ptr, CL_LPR, CL_GPR);
          wr_win = pair_winner(busy[CL_TPW], busy[CL_GPW], wr_pair_ptr, CL_TPW, CL_GPW);
          cand[0] = rd_win;
          cand[1] = wr_win;
          cand[2] = busy[CL_HPR] ? CL_HPR : NO_CLASS;
          cand[3] = busy[CL_CMO] ? CL_CMO : NO_CLASS;
          for (int i = 0; i < 4; i++) begin
            k = grp_ptr + 2'(i + 1);
            if (cand[k] != NO_CLASS) begin
              won = cand[k];
              grp_ptr = k;
              break;
            end
          end
          rd_pair_ptr = pair_ptr_next(rd_pair_ptr, rd_win, won,
                                      busy[CL_LPR] && busy[CL_GPR], CL_LPR);
          wr_pair_ptr = pair_ptr_next(wr_pair_ptr, wr_win, won,
                                      busy[CL_TPW] && busy[CL_GPW], CL_TPW);
        end
        // Source round robin inside the winning class, starting past its pointer.
        if (won != NO_CLASS) begin
          for (int i = 0; i < SOURCE_COUNT; i++) begin
            s = (int'(src_ptr[won]) + 1 + i) % SOURCE_COUNT;
            if (retry_cnt[won][s] != '0) begin
              retry_cnt[won][s] -= 1'b1;
              src_ptr[won] = SRC_W'(s);
              res.grant_valid  = 1'b1;
              res.grant_class  = won;
              res.grant_source = 4'(s);
              break;
            end
          end
        end
      end
      default: res.status = ST_BAD_INDEX;
    endcase
    busy = busy_classes();
    res.pending_mask = busy;
    res.all_empty    = (busy == '0);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver. Requests go out in bursts of random length separated by
  // random gaps; a gap of zero gives long stretches of back-to-back requests.
  // A request is held stable while tready is low. The prediction is made at
  // the edge where the request is taken, so model order matches block order.
  // ---------------------------------------------------------------------------
  retry_req_t active_req;
  int         burst_left = 8;
  int         idle_left  = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        predicted_results = {predicted_results, apply_retry_request(active_req)};
      if (s_tvalid && !s_tready) begin
        // Stalled: keep the current request on the bus.
      end else if (idle_left > 0) begin
        idle_left--;
        s_tvalid <= 1'b0;
      end else if (queued_requests.size() != 0 &&
                   !(queued_requests[0].drain_first && predicted_results.size() != 0)) begin
        active_req = queued_requests.pop_front();
        s_tdata  <= IN_DATA_W'({active_req.gpw_aged, active_req.gpr_aged,
                                active_req.source, active_req.req_class});
        s_tuser  <= active_req.func;
        s_tvalid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor. The receiver picks its mode at random from always ready,
  // mostly ready, mostly stalled and a fixed on/off rhythm.
  // Each result taken is compared with the oldest prediction.
  // ---------------------------------------------------------------------------
  int            stall_clock = 0;
  int            stall_mode  = 0;
  retry_result_t seen_result;
  retry_result_t want_result;

  task automatic check_field(string name, int unsigned want, int unsigned seen);
    if (want != seen) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_result = retry_result_t'(m_tdata[$bits(retry_result_t)-1:0]);
      if (predicted_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual %h", $time, seen_result);
      end else begin
        want_result = predicted_results.pop_front();
        check_field("grant_valid", want_result.grant_valid, seen_result.grant_valid);
        check_field("grant_class", want_result.grant_class, seen_result.grant_class);
        check_field("grant_source", want_result.grant_source, seen_result.grant_source);
        check_field("pending_mask", want_result.pending_mask, seen_result.pending_mask);
        check_field("all_empty", want_result.all_empty, seen_result.all_empty);
        check_field("status", want_result.status, seen_result.status);
      end
    end
    stall_clock++;
    if (stall_clock % 48 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 3) != 0);
      2:       m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ((stall_clock % 7) >= 3);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic queue_req(logic [1:0] func, logic [CLASS_W-1:0] cls, logic [3:0] src,
                           logic gpr_aged, logic gpw_aged);
    retry_req_t rq;
    rq.func        = func;
    rq.req_class   = cls;
    rq.source      = src;
    rq.gpr_aged    = gpr_aged;
    rq.gpw_aged    = gpw_aged;
    rq.drain_first = 1'b0;
    queued_requests = {queued_requests, rq};
  endtask

  // Random mix: records and grants dominate so counters fill and drain, with
  // sources bunched on a few low indexes so releases often find a retry.
  // A small share is noise: the unused function or an invalid class.
  task automatic queue_random_reqs(int count);
    int                 pick;
    logic [CLASS_W-1:0] cls;
    logic [3:0]         src;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      cls  = CLASS_W'($urandom_range(0, CLASS_COUNT - 1));
      src  = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
      if (pick < 40)
        queue_req(FN_RECORD, cls, src, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else if (pick < 58)
        queue_req(FN_RELEASE, cls, src, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else if (pick < 92)
        queue_req(FN_GRANT, cls, src, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else if (pick < 96)
        queue_req(FN_UNUSED, CLASS_W'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else
        queue_req(($urandom_range(0, 1) == 0) ? FN_RECORD : FN_RELEASE,
                  ($urandom_range(0, 1) == 0) ? CL_SPARE : NO_CLASS, src,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      // Now and then the sender waits for every outstanding result first.
      if ($urandom_range(0, 59) == 0) queued_requests[$].drain_first = 1'b1;
    end
  endtask

  // Waits until every request has been sent and every result has come back.
  task automatic wait_quiet();
    do @(negedge clk);
    while (queued_requests.size() != 0 || s_tvalid || predicted_results.size() != 0);
    repeat (2 * GRANT_CYCLES + 2) @(negedge clk);
  endtask

  task automatic write_age_reg(logic idx, logic val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_GPR_AGE) gpr_age_en = val;
    else gpw_age_en = val;
  endtask

  task automatic set_age_enables(logic gpr_en, logic gpw_en);
    write_age_reg(CFG_GPR_AGE, gpr_en);
    write_age_reg(CFG_GPW_AGE, gpw_en);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence. Configuration only changes while the block is idle.
  // ---------------------------------------------------------------------------
  initial begin
    for (int c = 0; c < CLASS_COUNT; c++) begin
      for (int s = 0; s < SOURCE_COUNT; s++) retry_cnt[c][s] = '0;
      src_ptr[c] = SRC_W'(SOURCE_COUNT - 1);
    end
    rd_pair_ptr = 1'b0;
    wr_pair_ptr = 1'b0;
    grp_ptr     = 2'd3;
    gpr_age_en  = 1'b0;
    gpw_age_en  = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Phase one: aging off. Directed cases first.
    set_age_enables(1'b0, 1'b0);
    // Grant with nothing pending, then a release at zero.
    queue_req(FN_GRANT, CL_HPR, 4'd0, 1'b1, 1'b1);
    queue_req(FN_RELEASE, CL_HPR, 4'd0, 1'b0, 1'b0);
    // Invalid classes and the unused function are rejected with a bad-index status.
    queue_req(FN_RECORD, CL_SPARE, 4'd15, 1'b0, 1'b0);
    queue_req(FN_RELEASE, NO_CLASS, 4'd0, 1'b0, 1'b0);
    queue_req(FN_UNUSED, CL_CMO, 4'd15, 1'b1, 1'b1);
    // At least one retry in every class with both pairs fully busy, lowest and highest sources.
    queue_req(FN_RECORD, CL_HPR, 4'd15, 1'b0, 1'b0);
    queue_req(FN_RECORD, CL_LPR, 4'd0, 1'b0, 1'b0);
    queue_req(FN_RECORD, CL_GPR, 4'd15, 1'b0, 1'b0);
    queue_req(FN_RECORD, CL_GPR, 4'd3, 1'b0, 1'b0);
    queue_req(FN_RECORD, CL_TPW, 4'd0, 1'b0, 1'b0);
    queue_req(FN_RECORD, CL_GPW, 4'd15, 1'b0, 1'b0);
    queue_req(FN_RECORD, CL_GPW, 4'd8, 1'b0, 1'b0);
    queue_req(FN_RECORD, CL_CMO, 4'd0, 1'b0, 1'b0);
    queue_req(FN_RELEASE, CL_GPW, 4'd8, 1'b0, 1'b0);
    // Drain with grants; the aged flags must have no effect while aging is off.
    for (int i = 0; i < 8; i++)
      queue_req(FN_GRANT, CL_HPR, 4'd0, i[0], i[1]);
    queue_random_reqs(250);
    wait_quiet();

    // Phase two: both aging paths on. Fill one counter past its limit.
    set_age_enables(1'b1, 1'b1);
    for (int i = 0; i < 257; i++)
      queue_req(FN_RECORD, CL_GPR, 4'd9, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    queue_random_reqs(250);
    wait_quiet();

    // Phase three: only the GPR aging path.
    set_age_enables(1'b1, 1'b0);
    queue_random_reqs(250);
    wait_quiet();

    // Phase four: only the GPW aging path.
    set_age_enables(1'b0, 1'b1);
    queue_random_reqs(250);
    wait_quiet();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
